// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; each macro takes a clock and a property, and ASSERT_CLK also an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge while out of reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, but also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/ppacb_pkg.sv =====
// Shared types and constants of the ping-pong audio capture buffer.
// No dependencies; imported by the store, the top level and the checker.
`timescale 1ns / 1ps

package ppacb_pkg;

    // Default size of one ping-pong half, in bytes
    localparam int DEFAULT_BUFFER_DEPTH = 1024;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int ADC_W    = 12;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 11;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Register reset values and the minimum active length
    localparam logic [POS_W-1:0] BUFFER_BYTES_RST = 11'd1024;
    localparam logic [ADC_W-1:0] ADC_CENTER_RST   = 12'd2060;
    localparam logic [POS_W-1:0] MIN_LENGTH       = 11'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_CENTER   = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_DRAIN  = 2'd1,
        MODE_START  = 2'd2,
        MODE_FINISH = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED    = 3'd0,
        ST_OVERRUN   = 3'd1,
        ST_NOT_ARMED = 3'd2,
        ST_DRAIN     = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_CTRL_DONE = 3'd5
    } status_t;

endpackage

// ===== src/ppacb_store.sv =====
// Sample store: one 16-bit word per sample, one write and one registered read per cycle.
// Depends on ppacb_pkg.
`timescale 1ns / 1ps

module ppacb_store
    import ppacb_pkg::*;
#(
    parameter int WORDS = DEFAULT_BUFFER_DEPTH,
    parameter int AW    = $clog2(WORDS)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [WORDS];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/pingpong_audio_capture_buffer_unit.sv =====
// Top level of the ping-pong audio capture buffer: control state, store access, result stage.
// Depends on ppacb_pkg and ppacb_store.
`timescale 1ns / 1ps
// A result is presented in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle while results are taken; the store takes one write or
// one read per item, and the result register frees each cycle the downstream side takes it.
// Reset (aresetn low at a rising edge) frees both buffers, disarms capture, clears
// positions and selects, and restores the register defaults; the store is not cleared.

module pingpong_audio_capture_buffer_unit
    import ppacb_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEFAULT_BUFFER_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [11:0] adc_value
    input  logic [MODE_W-1:0]     s_tuser,   // [1:0] mode
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] data_byte, [8] buffer_filled
    output logic [STATUS_W-1:0]   m_tuser,   // [2:0] status
    output logic                  m_tlast    // last_of_buffer
);

    localparam int HALF_WORDS = BUFFER_DEPTH / 2;
    localparam int WORDS      = 2 * HALF_WORDS;
    localparam int AW         = $clog2(WORDS);
    localparam int CAP        = 2 * HALF_WORDS;

    // Configuration registers
    logic [POS_W-1:0] buffer_bytes_reg;
    logic [ADC_W-1:0] adc_center_reg;

    // Control state
    logic [1:0]       free_reg, free_next;
    logic             fill_sel_reg, fill_sel_next;
    logic             drain_sel_reg, drain_sel_next;
    logic [POS_W-1:0] fill_pos_reg, fill_pos_next;
    logic [POS_W-1:0] drain_pos_reg, drain_pos_next;
    logic [1:0]       pending_reg, pending_next;
    logic             armed_reg, armed_next;

    // Result stage
    logic    out_valid_reg;
    status_t status_reg, status_next;
    logic    last_reg, last_next;
    logic    filled_reg, filled_next;
    logic    hi_byte_reg;

    // Store access
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [SAMPLE_W-1:0] sample_val, rd_data;

    logic             accept;
    mode_t            mode;
    logic [ADC_W-1:0] adc_value;
    logic [POS_W-1:0] len_even, active_len, fill_pos_inc;
    logic [POS_W:0]   drain_pos_inc;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign mode      = mode_t'(s_tuser);
    assign adc_value = s_tdata[ADC_W-1:0];

    // Active length: even, at least two, at most the half size
    always_comb begin
        len_even = {buffer_bytes_reg[POS_W-1:1], 1'b0};
        if (len_even < MIN_LENGTH) begin
            active_len = MIN_LENGTH;
        end else if (32'(len_even) > 32'(CAP)) begin
            active_len = POS_W'(CAP);
        end else begin
            active_len = len_even;
        end
    end

    assign sample_val    = {{(SAMPLE_W-ADC_W){1'b0}}, adc_value}
                         - {{(SAMPLE_W-ADC_W){1'b0}}, adc_center_reg};
    assign fill_pos_inc  = fill_pos_reg + POS_W'(2);
    assign drain_pos_inc = {1'b0, drain_pos_reg} + (POS_W+1)'(1);

    // Word addresses; each half starts at its own word boundary
    assign wr_addr = fill_sel_reg
                   ? AW'(HALF_WORDS + 32'(fill_pos_reg[POS_W-1:1]))
                   : AW'(fill_pos_reg[POS_W-1:1]);
    assign rd_addr = drain_sel_reg
                   ? AW'(HALF_WORDS + 32'(drain_pos_reg[POS_W-1:1]))
                   : AW'(drain_pos_reg[POS_W-1:1]);

    // Per-transaction state update and result
    always_comb begin
        free_next      = free_reg;
        fill_sel_next  = fill_sel_reg;
        drain_sel_next = drain_sel_reg;
        fill_pos_next  = fill_pos_reg;
        drain_pos_next = drain_pos_reg;
        pending_next   = pending_reg;
        armed_next     = armed_reg;
        status_next    = ST_CTRL_DONE;
        last_next      = 1'b0;
        filled_next    = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        case (mode)
            MODE_SAMPLE: begin
                if (!armed_reg) begin
                    status_next = ST_NOT_ARMED;
                end else if (!free_reg[fill_sel_reg]) begin
                    status_next = ST_OVERRUN;
                end else begin
                    status_next = ST_STORED;
                    wr_en       = accept;
                    if (fill_pos_inc >= active_len) begin
                        free_next[fill_sel_reg] = 1'b0;
                        fill_pos_next = '0;
                        fill_sel_next = !fill_sel_reg;
                        if (pending_reg < 2'd2) begin
                            pending_next = pending_reg + 2'd1;
                        end
                        filled_next = 1'b1;
                    end else begin
                        fill_pos_next = fill_pos_inc;
                    end
                end
            end
            MODE_DRAIN: begin
                if (pending_reg == 2'd0) begin
                    status_next = ST_EMPTY;
                end else begin
                    status_next = ST_DRAIN;
                    rd_en       = accept;
                    if (drain_pos_inc >= {1'b0, active_len}) begin
                        last_next = 1'b1;
                        free_next[drain_sel_reg] = 1'b1;
                        drain_pos_next = '0;
                        drain_sel_next = !drain_sel_reg;
                        pending_next   = pending_reg - 2'd1;
                    end else begin
                        drain_pos_next = drain_pos_inc[POS_W-1:0];
                    end
                end
            end
            MODE_START: begin
                free_next      = 2'b11;
                fill_sel_next  = 1'b0;
                drain_sel_next = 1'b0;
                fill_pos_next  = '0;
                drain_pos_next = '0;
                pending_next   = 2'd0;
                armed_next     = 1'b1;
            end
            MODE_FINISH: begin
                armed_next = 1'b0;
            end
            default: begin
                status_next = ST_CTRL_DONE;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_bytes_reg <= BUFFER_BYTES_RST;
            adc_center_reg   <= ADC_CENTER_RST;
        end else if (cfg_we) begin
            if (cfg_index == CFG_BUFFER_BYTES) begin
                buffer_bytes_reg <= cfg_wdata[POS_W-1:0];
            end else if (cfg_index == CFG_ADC_CENTER) begin
                adc_center_reg <= cfg_wdata[ADC_W-1:0];
            end
        end
    end

    // Control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg      <= 2'b11;
            fill_sel_reg  <= 1'b0;
            drain_sel_reg <= 1'b0;
            fill_pos_reg  <= '0;
            drain_pos_reg <= '0;
            pending_reg   <= 2'd0;
            armed_reg     <= 1'b0;
        end else if (accept) begin
            free_reg      <= free_next;
            fill_sel_reg  <= fill_sel_next;
            drain_sel_reg <= drain_sel_next;
            fill_pos_reg  <= fill_pos_next;
            drain_pos_reg <= drain_pos_next;
            pending_reg   <= pending_next;
            armed_reg     <= armed_next;
        end
    end

    // Result stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    // Result stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            last_reg    <= last_next;
            filled_reg  <= filled_next;
            hi_byte_reg <= drain_pos_reg[0];
        end
    end

    ppacb_store #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sample_val),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output mapping; the drained byte is chosen from the registered store word
    always_comb begin
        m_tdata = '0;
        if (status_reg == ST_DRAIN) begin
            m_tdata[BYTE_W-1:0] = hi_byte_reg ? rd_data[SAMPLE_W-1:BYTE_W]
                                              : rd_data[BYTE_W-1:0];
        end
        m_tdata[BYTE_W] = filled_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== src/ppacb_checker.sv =====
// Port-level checker for the ping-pong audio capture buffer, bound to the top level.
// Depends on ppacb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppacb_checker
    import ppacb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_wdata,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [15:0]           s_tdata,
    input logic [MODE_W-1:0]     s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [15:0]           m_tdata,
    input logic [STATUS_W-1:0]   m_tuser,
    input logic                  m_tlast
);

    // A stalled result stays presented
    `ASSERT_CLK(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    // Every accepted transaction yields a result in the next cycle
    `ASSERT_CLK(a_one_result, aclk, aresetn, s_tvalid && s_tready |=> m_tvalid, "accepted transaction produced no result")

    // Only drained bytes carry data or the last-byte mark
    `ASSERT_CLK(a_drain_only, aclk, aresetn, m_tvalid && m_tuser != ST_DRAIN |-> m_tdata[7:0] == 8'd0 && !m_tlast, "data or last outside a drain")

    // A completed buffer is only reported with a stored sample
    `ASSERT_CLK(a_filled_stored, aclk, aresetn, m_tvalid && m_tdata[8] |-> m_tuser == ST_STORED, "buffer filled without a stored sample")

    // Input side is ready whenever the result stage is empty
    `ASSERT_CLK(a_ready_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with an empty result stage")

endmodule

bind pingpong_audio_capture_buffer_unit ppacb_checker u_ppacb_checker (.*);
